// ===== rtl/core/dds_tuning_word_keypad_loader_defines.svh =====
// Assertion macros shared by the keypad loader RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef DDS_TUNING_WORD_KEYPAD_LOADER_DEFINES_SVH
`define DDS_TUNING_WORD_KEYPAD_LOADER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DTWKL_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("keypad loader check failed");

// Next-cycle implication, disabled while reset is asserted.
`define DTWKL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("keypad loader check failed");

`endif

// ===== rtl/core/dtwkl_pkg.sv =====
// Types, constants and the key decode function of the keypad loader.
// Depends on nothing; used by dds_tuning_word_keypad_loader.
package dtwkl_pkg;

	localparam int KEY_W     = 5;
	localparam int REF_W     = 27;
	localparam int DISPLAY_W = 10;
	localparam int BYTE_W    = 8;
	localparam int WORD_W    = 32;
	localparam int MULT_W    = 20;

	localparam logic [KEY_W-1:0] KEY_START = 5'd1;
	localparam logic [KEY_W-1:0] KEY_SCALE = 5'd2;

	localparam logic [1:0] SCALE_HZ  = 2'd0;
	localparam logic [1:0] SCALE_KHZ = 2'd1;
	localparam logic [1:0] SCALE_MHZ = 2'd2;

	localparam logic [MULT_W-1:0] MULT_KHZ = 20'd1000;
	localparam logic [MULT_W-1:0] MULT_MHZ = 20'd1000000;

	localparam logic [REF_W-1:0] REF_CLOCK_RESET = 27'd125000000;

	typedef struct packed {
		logic       valid;
		logic [3:0] value;
	} digit_t;

	// Keypad matrix code to decimal digit.
	function automatic digit_t map_digit(input logic [KEY_W-1:0] code);
		digit_t d;
		d.valid = 1'b1;
		case (code)
			5'd13:   d.value = 4'd1;
			5'd16:   d.value = 4'd2;
			5'd14:   d.value = 4'd3;
			5'd9:    d.value = 4'd4;
			5'd12:   d.value = 4'd5;
			5'd10:   d.value = 4'd6;
			5'd5:    d.value = 4'd7;
			5'd8:    d.value = 4'd8;
			5'd6:    d.value = 4'd9;
			5'd4:    d.value = 4'd0;
			default: begin
				d.valid = 1'b0;
				d.value = 4'd0;
			end
		endcase
		return d;
	endfunction

endpackage

// ===== rtl/core/dds_tuning_word_keypad_loader.sv =====
// Keypad loader top: decimal entry, unit scale and DDS tuning word; needs dtwkl_pkg and defines.
// A start key runs multiply, compare, 33 divide steps and the output register; a word clamped early
// skips the divide. Keys are taken one at a time: the input stays closed until the last result
// of a key enters the output register, and a stalled result transfer keeps it closed longer.
// Reset (arst_n low, asynchronous) clears the entry, selects Hz and a 125000000 Hz ref clock.
`include "dds_tuning_word_keypad_loader_defines.svh"

module dds_tuning_word_keypad_loader #(
	parameter int DIGIT_COUNT = 3
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// Configuration: reference clock in hertz.
	input  logic                        cfg_we,
	input  logic [dtwkl_pkg::REF_W-1:0] cfg_wdata,
	// Key input. tdata bits: [4:0] key_code, [7:5] zero.
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [7:0]                  s_tdata,
	// Results. tdata bits: [9:0] display_value, [11:10] scale_sel,
	// [19:12] load_byte, [20] saturated, [23:21] zero.
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [23:0]                 m_tdata,
	output logic                        m_tuser, // kind: 0 display, 1 load byte
	output logic                        m_tlast
);
	import dtwkl_pkg::*;

	// Widths that follow from the number of digits.
	localparam int VAL_W = $clog2(10 ** DIGIT_COUNT);
	localparam int F_W   = VAL_W + MULT_W;
	localparam int IDX_W = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;
	localparam int DIV_STEPS = WORD_W + 1;
	localparam int DCNT_W = $clog2(DIV_STEPS);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ACCUM,
		ST_DISP,
		ST_MUL,
		ST_CMP,
		ST_DIV,
		ST_EMIT
	} state_t;

	state_t state_q;

	// Architectural state.
	logic [3:0]       digits_q [DIGIT_COUNT];
	logic [1:0]       scale_q;
	logic [REF_W-1:0] ref_q;
	logic [VAL_W-1:0] val_q;    // decimal value of the entry, kept current

	// Sequencer and datapath registers.
	logic [IDX_W-1:0]  dig_cnt_q;
	logic [DCNT_W-1:0] div_cnt_q;
	logic [F_W-1:0]    f_q;
	logic [REF_W:0]    rem_q;
	logic [WORD_W:0]   div_bits_q;  // low numerator bits, shifted out MSB first
	logic [WORD_W-1:0] quo_q;
	logic [WORD_W-1:0] word_q;
	logic              sat_q;
	logic [2:0]        byte_cnt_q;

	// Output register.
	logic                 m_valid_q;
	logic [DISPLAY_W-1:0] o_disp_q;
	logic [1:0]           o_scale_q;
	logic [BYTE_W-1:0]    o_byte_q;
	logic                 o_sat_q;
	logic                 o_kind_q;
	logic                 o_last_q;

	logic [KEY_W-1:0]  key;
	digit_t            key_digit;
	logic              in_xfer;
	logic              out_free;
	logic              out_load;
	logic [VAL_W+3:0]  acc_wide;
	logic [MULT_W-1:0] scale_mult;
	logic [F_W-1:0]    product;
	logic [REF_W+1:0]  trial;
	logic [REF_W+1:0]  divisor;
	logic [REF_W+1:0]  diff;
	logic              trial_ge;
	logic [BYTE_W-1:0] emit_byte;

	assign key       = s_tdata[KEY_W-1:0];
	assign key_digit = map_digit(key);
	assign s_tready  = (state_q == ST_IDLE);
	assign in_xfer   = s_tvalid && s_tready;
	assign out_free  = !m_valid_q || m_tready;
	// A new result enters the output register in this cycle.
	assign out_load  = out_free && (state_q == ST_DISP || state_q == ST_EMIT);

	// Horner step of the entry value: val * 10 + digit, most significant digit first.
	assign acc_wide = {1'b0, val_q, 3'b000} + {3'b000, val_q, 1'b0}
		+ (VAL_W + 4)'(digits_q[dig_cnt_q]);

	always_comb begin
		case (scale_q)
			SCALE_KHZ: scale_mult = MULT_KHZ;
			SCALE_MHZ: scale_mult = MULT_MHZ;
			default:   scale_mult = MULT_W'(1);
		endcase
	end

	assign product = F_W'(val_q) * F_W'(scale_mult);

	// Restoring divide step. The numerator is f*2^33 + ref and the divisor 2*ref;
	// since f < ref the remainder starts as f and 33 low bits remain to shift in.
	assign trial    = {rem_q, div_bits_q[WORD_W]};
	assign divisor  = {1'b0, ref_q, 1'b0};
	assign trial_ge = (trial >= divisor);
	assign diff     = trial - divisor;

	// Load sequence: a zero control byte, then the word MSB first.
	always_comb begin
		case (byte_cnt_q)
			3'd1:    emit_byte = word_q[31:24];
			3'd2:    emit_byte = word_q[23:16];
			3'd3:    emit_byte = word_q[15:8];
			3'd4:    emit_byte = word_q[7:0];
			default: emit_byte = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			for (int i = 0; i < DIGIT_COUNT; i++) begin
				digits_q[i] <= 4'd0;
			end
			scale_q    <= SCALE_HZ;
			ref_q      <= REF_CLOCK_RESET;
			val_q      <= '0;
			dig_cnt_q  <= '0;
			div_cnt_q  <= '0;
			f_q        <= '0;
			rem_q      <= '0;
			div_bits_q <= '0;
			quo_q      <= '0;
			word_q     <= '0;
			sat_q      <= 1'b0;
			byte_cnt_q <= '0;
			m_valid_q  <= 1'b0;
			o_disp_q   <= '0;
			o_scale_q  <= '0;
			o_byte_q   <= '0;
			o_sat_q    <= 1'b0;
			o_kind_q   <= 1'b0;
			o_last_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				ref_q <= cfg_wdata;
			end
			if (out_load) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						if (key == KEY_SCALE) begin
							scale_q <= (scale_q == SCALE_MHZ) ? SCALE_HZ : scale_q + 2'd1;
							state_q <= ST_DISP;
						end else if (key == KEY_START) begin
							state_q <= ST_MUL;
						end else if (key_digit.valid) begin
							for (int i = DIGIT_COUNT - 1; i > 0; i--) begin
								digits_q[i] <= digits_q[i-1];
							end
							digits_q[0] <= key_digit.value;
							val_q       <= '0;
							dig_cnt_q   <= IDX_W'(DIGIT_COUNT - 1);
							state_q     <= ST_ACCUM;
						end
					end
				end
				ST_ACCUM: begin
					val_q <= acc_wide[VAL_W-1:0];
					if (dig_cnt_q == '0) begin
						state_q <= ST_DISP;
					end else begin
						dig_cnt_q <= dig_cnt_q - IDX_W'(1);
					end
				end
				ST_DISP: begin
					if (out_free) begin
						o_kind_q  <= 1'b0;
						o_disp_q  <= DISPLAY_W'(val_q);
						o_scale_q <= scale_q;
						o_byte_q  <= '0;
						o_sat_q   <= 1'b0;
						o_last_q  <= 1'b1;
						state_q   <= ST_IDLE;
					end
				end
				ST_MUL: begin
					f_q     <= product;
					state_q <= ST_CMP;
				end
				ST_CMP: begin
					byte_cnt_q <= '0;
					if (f_q >= F_W'(ref_q)) begin
						word_q  <= '1;
						sat_q   <= 1'b1;
						state_q <= ST_EMIT;
					end else begin
						rem_q      <= {1'b0, f_q[REF_W-1:0]};
						div_bits_q <= (WORD_W + 1)'(ref_q);
						quo_q      <= '0;
						div_cnt_q  <= DCNT_W'(DIV_STEPS - 1);
						state_q    <= ST_DIV;
					end
				end
				ST_DIV: begin
					rem_q      <= trial_ge ? diff[REF_W:0] : trial[REF_W:0];
					div_bits_q <= {div_bits_q[WORD_W-1:0], 1'b0};
					quo_q      <= {quo_q[WORD_W-2:0], trial_ge};
					if (div_cnt_q == '0) begin
						// The quotient has 33 bits; its top bit is the MSB of quo_q
						// here, and a set top bit means the word overflowed.
						if (quo_q[WORD_W-1]) begin
							word_q <= '1;
							sat_q  <= 1'b1;
						end else begin
							word_q <= {quo_q[WORD_W-2:0], trial_ge};
						end
						state_q <= ST_EMIT;
					end else begin
						div_cnt_q <= div_cnt_q - DCNT_W'(1);
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						o_kind_q  <= 1'b1;
						o_disp_q  <= DISPLAY_W'(val_q);
						o_scale_q <= scale_q;
						o_byte_q  <= emit_byte;
						o_sat_q   <= sat_q;
						o_last_q  <= (byte_cnt_q == 3'd4);
						if (byte_cnt_q == 3'd4) begin
							sat_q   <= 1'b0;
							state_q <= ST_IDLE;
						end else begin
							byte_cnt_q <= byte_cnt_q + 3'd1;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {3'b000, o_sat_q, o_byte_q, o_scale_q, o_disp_q};
	assign m_tuser  = o_kind_q;
	assign m_tlast  = o_last_q;

	// A display update is always the only result of its key.
	`DTWKL_ASSERT_IMPL(a_disp_is_last, clk, arst_n, m_tvalid && !m_tuser, m_tlast)
	// The clamp flag only ever rides on load bytes.
	`DTWKL_ASSERT_IMPL(a_sat_on_load, clk, arst_n, m_tvalid && m_tdata[20], m_tuser)
	// A start key keeps the input closed while the word is worked out.
	`DTWKL_ASSERT_NEXT(a_start_busy, clk, arst_n,
		s_tvalid && s_tready && s_tdata[KEY_W-1:0] == KEY_START, !s_tready)
	// The unit scale never leaves Hz, kHz and MHz.
	`DTWKL_ASSERT_IMPL(a_scale_range, clk, arst_n, m_tvalid, m_tdata[11:10] != 2'd3)

endmodule
